@@ hdl/byte_stack_machine_core_assert.svh @@
// Assertion macros shared by the stack machine modules.
// Expects signals named clock and reset in the scope of each use.
`ifndef BYTE_STACK_MACHINE_CORE_ASSERT_SVH
`define BYTE_STACK_MACHINE_CORE_ASSERT_SVH

// Same-cycle implication.
`define BSM_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("bsm assertion failed");

// Next-cycle implication.
`define BSM_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("bsm assertion failed");

`endif

@@ hdl/bsm_pkg.sv @@
// Package for the byte stack machine: sizes, codes, jump table and the
// controller/datapath command and status structs. No dependencies.
package bsm_pkg;

   localparam int PROG_WORDS  = 128;
   localparam int PROG_AW     = $clog2(PROG_WORDS);
   localparam int STACK_WORDS = 128;
   localparam int STACK_AW    = $clog2(STACK_WORDS);
   localparam int LEVEL_W     = $clog2(STACK_WORDS + 1);
   localparam int DIV_STEPS   = 8;
   localparam int DIV_CW      = $clog2(DIV_STEPS + 1);

   typedef logic [PROG_AW-1:0]  prog_addr_type;
   typedef logic [STACK_AW-1:0] stack_addr_type;
   typedef logic [LEVEL_W-1:0]  level_type;
   typedef logic [DIV_CW-1:0]   div_count_type;
   typedef logic [7:0]          byte_type;
   typedef logic [11:0]         prog_word_type;

   // request opcodes
   localparam logic [1:0] REQ_WRITE = 2'd0;
   localparam logic [1:0] REQ_START = 2'd1;
   localparam logic [1:0] REQ_STEP  = 2'd2;

   // program word ops
   localparam logic [3:0] OP_NOP       = 4'd0;
   localparam logic [3:0] OP_PUSH      = 4'd1;
   localparam logic [3:0] OP_POP       = 4'd2;
   localparam logic [3:0] OP_ADD       = 4'd3;
   localparam logic [3:0] OP_SUB       = 4'd4;
   localparam logic [3:0] OP_MUL       = 4'd5;
   localparam logic [3:0] OP_DIV       = 4'd6;
   localparam logic [3:0] OP_CMP       = 4'd7;
   localparam logic [3:0] OP_INPUT     = 4'd8;
   localparam logic [3:0] OP_SHOW_TOP  = 4'd9;
   localparam logic [3:0] OP_SHOW_CHAR = 4'd10;
   localparam logic [3:0] OP_JMP       = 4'd11;
   localparam logic [3:0] OP_JEQ       = 4'd12;
   localparam logic [3:0] OP_JGT       = 4'd13;
   localparam logic [3:0] OP_JLT       = 4'd14;
   localparam logic [3:0] OP_HALT      = 4'd15;

   // display kinds
   localparam logic [1:0] SHOW_NONE = 2'd0;
   localparam logic [1:0] SHOW_CHAR = 2'd1;
   localparam logic [1:0] SHOW_HEX  = 2'd2;

   // fault codes
   localparam logic [2:0] FAULT_NONE      = 3'd0;
   localparam logic [2:0] FAULT_OVERFLOW  = 3'd1;
   localparam logic [2:0] FAULT_UNDERFLOW = 3'd2;
   localparam logic [2:0] FAULT_HALT      = 3'd3;
   localparam logic [2:0] FAULT_DIV_ZERO  = 3'd4;

   // jump target: argument folded into the program store
   typedef prog_addr_type jump_table_type [256];

   function automatic jump_table_type build_jump_table();
      jump_table_type t;
      for (int i = 0; i < 256; i++) begin
         t[i] = prog_addr_type'(i % PROG_WORDS);
      end
      return t;
   endfunction

   localparam jump_table_type JUMP_SLOT = build_jump_table();

   typedef struct packed {
      logic       prog_write;
      logic       start;
      logic       rd_second;
      logic       load_a;
      logic       load_b;
      logic       push;
      logic       pop;
      logic       store;
      logic       ip_next;
      logic       ip_jump;
      logic       cmp;
      logic       div_start;
      logic       div_step;
      logic       halt;
      logic       rsp_set;
      logic [1:0] kind;
      logic [2:0] fault;
   } dp_cmd_type;

   typedef struct packed {
      logic [3:0] op;
      logic       level_zero;
      logic       level_lt2;
      logic       level_full;
      logic       eq_flag;
      logic       lt_flag;
      logic       running;
      logic       b_zero;
      logic       div_done;
   } dp_status_type;

endpackage

@@ hdl/bsm_ifs.sv @@
// Valid/ready channel interfaces for requests and responses.
// Depends on nothing.
interface bsm_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] opcode;
   logic [6:0] word_address;
   logic [3:0] word_op;
   logic [7:0] word_arg;

   modport source (output valid, opcode, word_address, word_op, word_arg, input ready);
   modport sink (input valid, opcode, word_address, word_op, word_arg, output ready);
endinterface

interface bsm_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] show_kind;
   logic [7:0] show_value;
   logic       is_running;
   logic [2:0] fault_code;
   logic [6:0] pointer_now;

   modport source (output valid, show_kind, show_value, is_running, fault_code,
                   pointer_now, input ready);
   modport sink (input valid, show_kind, show_value, is_running, fault_code,
                 pointer_now, output ready);
endinterface

@@ hdl/byte_stack_machine_core.sv @@
// Byte stack machine top: controller plus datapath on valid/ready channels.
// Write, start, unused requests and a step while halted go straight to the response;
// a running step passes through fetch, then stack reads, divide and store as its op needs.
// One transaction at a time: next accept in the cycle after the response handshake;
// the single stack read port and the 8-step divider set the step length.
// Synchronous reset clears pointers, flags, running and program store valid bits.
module byte_stack_machine_core (
   input logic      clock,
   input logic      reset,
   bsm_req_if.sink   req_port,
   bsm_rsp_if.source rsp_port
);

   bsm_pkg::dp_cmd_type    cmd;
   bsm_pkg::dp_status_type sts;

   bsm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_port.valid),
      .req_opcode (req_port.opcode),
      .req_ready  (req_port.ready),
      .rsp_valid  (rsp_port.valid),
      .rsp_ready  (rsp_port.ready),
      .cmd        (cmd),
      .sts        (sts)
   );

   bsm_dpath u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sts          (sts),
      .word_address (req_port.word_address),
      .word_op      (req_port.word_op),
      .word_arg     (req_port.word_arg),
      .show_kind    (rsp_port.show_kind),
      .show_value   (rsp_port.show_value),
      .is_running   (rsp_port.is_running),
      .fault_code   (rsp_port.fault_code),
      .pointer_now  (rsp_port.pointer_now)
   );

endmodule

@@ hdl/bsm_dpath.sv @@
// Datapath: program store, data stack, pointers, flags, divider, response regs.
// Depends on bsm_pkg and byte_stack_machine_core_assert.svh.
`include "byte_stack_machine_core_assert.svh"

module bsm_dpath (
   input  logic                   clock,
   input  logic                   reset,
   input  bsm_pkg::dp_cmd_type    cmd,
   output bsm_pkg::dp_status_type sts,
   input  logic [6:0]             word_address,
   input  logic [3:0]             word_op,
   input  logic [7:0]             word_arg,
   output logic [1:0]             show_kind,
   output logic [7:0]             show_value,
   output logic                   is_running,
   output logic [2:0]             fault_code,
   output logic [6:0]             pointer_now
);

   bsm_pkg::prog_word_type               prog_mem [bsm_pkg::PROG_WORDS];
   logic [bsm_pkg::PROG_WORDS-1:0]       prog_valid_ff, prog_valid_in;
   bsm_pkg::prog_word_type               inst_ff;
   bsm_pkg::prog_addr_type               prog_waddr;
   logic                                 prog_hit;

   bsm_pkg::byte_type                    stack_mem [bsm_pkg::STACK_WORDS];
   bsm_pkg::byte_type                    stk_rd_ff;
   bsm_pkg::stack_addr_type              stk_raddr, stk_waddr;
   bsm_pkg::byte_type                    stk_wdata;
   logic                                 stk_we;

   bsm_pkg::prog_addr_type               ip_ff, ip_in, ip_inc;
   bsm_pkg::level_type                   level_ff, level_in;
   logic                                 eq_ff, eq_in, lt_ff, lt_in;
   logic                                 running_ff, running_in;
   bsm_pkg::byte_type                    a_ff, a_in, b_ff, b_in;
   bsm_pkg::byte_type                    rem_ff, rem_in, quo_ff, quo_in;
   bsm_pkg::div_count_type               cnt_ff, cnt_in;
   logic [1:0]                           kind_ff, kind_in;
   bsm_pkg::byte_type                    value_ff, value_in;
   logic [2:0]                           fault_ff, fault_in;

   logic [3:0]                           inst_op;
   bsm_pkg::byte_type                    inst_arg;
   logic [15:0]                          product;
   logic [8:0]                           rem_shift;
   logic [9:0]                           rem_diff;
   logic                                 rem_ge;
   bsm_pkg::byte_type                    alu_result;
   logic [8:0]                           ip_wide;

   assign inst_op  = inst_ff[11:8];
   assign inst_arg = inst_ff[7:0];

   // program store
   assign prog_hit   = {2'b00, word_address} < 9'(bsm_pkg::PROG_WORDS);
   assign prog_waddr = bsm_pkg::prog_addr_type'(word_address);

   always_comb begin
      prog_valid_in = prog_valid_ff;
      if (cmd.prog_write && prog_hit) begin
         prog_valid_in[prog_waddr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.prog_write && prog_hit) begin
         prog_mem[prog_waddr] <= {word_op, word_arg};
      end
      inst_ff <= prog_valid_ff[ip_ff] ? prog_mem[ip_ff] : '0;
   end

   // data stack
   assign stk_raddr = cmd.rd_second
                      ? bsm_pkg::stack_addr_type'(level_ff - bsm_pkg::level_type'(2))
                      : bsm_pkg::stack_addr_type'(level_ff - bsm_pkg::level_type'(1));
   assign stk_waddr = cmd.push
                      ? bsm_pkg::stack_addr_type'(level_ff)
                      : bsm_pkg::stack_addr_type'(level_ff - bsm_pkg::level_type'(2));
   assign stk_we    = cmd.push || cmd.store;

   assign product = {8'h00, a_ff} * {8'h00, b_ff};

   always_comb begin
      case (inst_op)
         bsm_pkg::OP_ADD: alu_result = bsm_pkg::byte_type'(a_ff + b_ff);
         bsm_pkg::OP_SUB: alu_result = bsm_pkg::byte_type'(a_ff - b_ff);
         bsm_pkg::OP_MUL: alu_result = product[7:0];
         default:         alu_result = quo_ff;
      endcase
   end

   assign stk_wdata = cmd.push ? inst_arg : alu_result;

   always_ff @(posedge clock) begin
      if (stk_we) begin
         stack_mem[stk_waddr] <= stk_wdata;
      end
      stk_rd_ff <= stack_mem[stk_raddr];
   end

   // restoring divider, one quotient bit per cycle
   assign rem_shift = {rem_ff, quo_ff[7]};
   assign rem_diff  = {1'b0, rem_shift} - {2'b00, b_ff};
   assign rem_ge    = !rem_diff[9];

   assign ip_inc = (ip_ff == bsm_pkg::prog_addr_type'(bsm_pkg::PROG_WORDS - 1))
                   ? '0 : bsm_pkg::prog_addr_type'(ip_ff + 1'b1);

   always_comb begin
      ip_in      = ip_ff;
      level_in   = level_ff;
      eq_in      = eq_ff;
      lt_in      = lt_ff;
      running_in = running_ff;
      a_in       = a_ff;
      b_in       = b_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      cnt_in     = cnt_ff;
      kind_in    = kind_ff;
      value_in   = value_ff;
      fault_in   = fault_ff;

      if (cmd.start) begin
         ip_in      = '0;
         level_in   = '0;
         eq_in      = 1'b0;
         lt_in      = 1'b0;
         running_in = 1'b1;
      end
      if (cmd.halt) begin
         running_in = 1'b0;
      end
      if (cmd.ip_next) begin
         ip_in = ip_inc;
      end
      if (cmd.ip_jump) begin
         ip_in = bsm_pkg::JUMP_SLOT[inst_arg];
      end
      if (cmd.push) begin
         level_in = bsm_pkg::level_type'(level_ff + 1'b1);
      end
      if (cmd.pop || cmd.store) begin
         level_in = bsm_pkg::level_type'(level_ff - 1'b1);
      end
      if (cmd.load_a) begin
         a_in = stk_rd_ff;
      end
      if (cmd.load_b) begin
         b_in = stk_rd_ff;
      end
      if (cmd.cmp) begin
         eq_in = (a_ff == stk_rd_ff);
         lt_in = (a_ff < stk_rd_ff);
      end
      if (cmd.div_start) begin
         quo_in = a_ff;
         rem_in = '0;
         cnt_in = bsm_pkg::div_count_type'(bsm_pkg::DIV_STEPS);
      end else if (cmd.div_step) begin
         rem_in = rem_ge ? rem_diff[7:0] : rem_shift[7:0];
         quo_in = {quo_ff[6:0], rem_ge};
         cnt_in = bsm_pkg::div_count_type'(cnt_ff - 1'b1);
      end
      if (cmd.rsp_set) begin
         kind_in  = cmd.kind;
         fault_in = cmd.fault;
         case (cmd.kind)
            bsm_pkg::SHOW_HEX:  value_in = stk_rd_ff;
            bsm_pkg::SHOW_CHAR: value_in = inst_arg;
            default:            value_in = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prog_valid_ff <= '0;
         ip_ff         <= '0;
         level_ff      <= '0;
         eq_ff         <= 1'b0;
         lt_ff         <= 1'b0;
         running_ff    <= 1'b0;
         cnt_ff        <= '0;
      end else begin
         prog_valid_ff <= prog_valid_in;
         ip_ff         <= ip_in;
         level_ff      <= level_in;
         eq_ff         <= eq_in;
         lt_ff         <= lt_in;
         running_ff    <= running_in;
         cnt_ff        <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff     <= a_in;
      b_ff     <= b_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      kind_ff  <= kind_in;
      value_ff <= value_in;
      fault_ff <= fault_in;
   end

   assign sts.op         = inst_op;
   assign sts.level_zero = (level_ff == '0);
   assign sts.level_lt2  = (level_ff < bsm_pkg::level_type'(2));
   assign sts.level_full = (level_ff == bsm_pkg::level_type'(bsm_pkg::STACK_WORDS));
   assign sts.eq_flag    = eq_ff;
   assign sts.lt_flag    = lt_ff;
   assign sts.running    = running_ff;
   assign sts.b_zero     = (stk_rd_ff == '0);
   assign sts.div_done   = (cnt_ff == '0);

   assign ip_wide     = 9'(ip_ff);
   assign show_kind   = kind_ff;
   assign show_value  = value_ff;
   assign is_running  = running_ff;
   assign fault_code  = fault_ff;
   assign pointer_now = ip_wide[6:0];

   `BSM_ASSERT_NOW(a_level_bound, 1'b1, level_ff <= bsm_pkg::level_type'(bsm_pkg::STACK_WORDS))
   `BSM_ASSERT_NOW(a_store_depth, cmd.store, level_ff >= bsm_pkg::level_type'(2))
   `BSM_ASSERT_NEXT(a_halt_stops, cmd.halt, !running_ff)

endmodule

@@ hdl/bsm_ctrl.sv @@
// Controller: sequences each step through fetch and, as its op needs, stack reads,
// divide and write-back. Depends on bsm_pkg and byte_stack_machine_core_assert.svh.
`include "byte_stack_machine_core_assert.svh"

module bsm_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic [1:0]             req_opcode,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output bsm_pkg::dp_cmd_type    cmd,
   input  bsm_pkg::dp_status_type sts
);

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_FETCH  = 7'b0000010,
      S_READ_A = 7'b0000100,
      S_READ_B = 7'b0001000,
      S_DIV    = 7'b0010000,
      S_STORE  = 7'b0100000,
      S_RESP   = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               unique case (req_opcode)
                  bsm_pkg::REQ_WRITE: begin
                     cmd.prog_write = 1'b1;
                     cmd.rsp_set    = 1'b1;
                     state_in       = S_RESP;
                  end
                  bsm_pkg::REQ_START: begin
                     cmd.start   = 1'b1;
                     cmd.rsp_set = 1'b1;
                     state_in    = S_RESP;
                  end
                  bsm_pkg::REQ_STEP: begin
                     if (sts.running) begin
                        state_in = S_FETCH;
                     end else begin
                        cmd.rsp_set = 1'b1;
                        state_in    = S_RESP;
                     end
                  end
                  default: begin
                     cmd.rsp_set = 1'b1;
                     state_in    = S_RESP;
                  end
               endcase
            end
         end
         S_FETCH: begin
            state_in    = S_RESP;
            cmd.rsp_set = 1'b1;
            unique case (sts.op) inside
               bsm_pkg::OP_PUSH: begin
                  if (sts.level_full) begin
                     cmd.halt  = 1'b1;
                     cmd.fault = bsm_pkg::FAULT_OVERFLOW;
                  end else begin
                     cmd.push    = 1'b1;
                     cmd.ip_next = 1'b1;
                  end
               end
               bsm_pkg::OP_POP: begin
                  if (sts.level_zero) begin
                     cmd.halt  = 1'b1;
                     cmd.fault = bsm_pkg::FAULT_UNDERFLOW;
                  end else begin
                     cmd.pop     = 1'b1;
                     cmd.ip_next = 1'b1;
                  end
               end
               bsm_pkg::OP_SHOW_TOP: begin
                  if (sts.level_zero) begin
                     cmd.halt  = 1'b1;
                     cmd.fault = bsm_pkg::FAULT_UNDERFLOW;
                  end else begin
                     cmd.rsp_set = 1'b0;
                     state_in    = S_READ_A;
                  end
               end
               bsm_pkg::OP_ADD, bsm_pkg::OP_SUB, bsm_pkg::OP_MUL, bsm_pkg::OP_DIV,
               bsm_pkg::OP_CMP: begin
                  if (sts.level_lt2) begin
                     cmd.halt  = 1'b1;
                     cmd.fault = bsm_pkg::FAULT_UNDERFLOW;
                  end else begin
                     cmd.rsp_set = 1'b0;
                     state_in    = S_READ_A;
                  end
               end
               bsm_pkg::OP_SHOW_CHAR: begin
                  cmd.kind    = bsm_pkg::SHOW_CHAR;
                  cmd.ip_next = 1'b1;
               end
               bsm_pkg::OP_JMP: begin
                  cmd.ip_jump = 1'b1;
               end
               bsm_pkg::OP_JEQ: begin
                  cmd.ip_jump = sts.eq_flag;
                  cmd.ip_next = !sts.eq_flag;
               end
               bsm_pkg::OP_JLT: begin
                  cmd.ip_jump = sts.lt_flag;
                  cmd.ip_next = !sts.lt_flag;
               end
               bsm_pkg::OP_JGT, bsm_pkg::OP_HALT: begin
                  cmd.halt  = 1'b1;
                  cmd.fault = bsm_pkg::FAULT_HALT;
               end
               default: begin
                  cmd.ip_next = 1'b1;
               end
            endcase
         end
         S_READ_A: begin
            cmd.load_a = 1'b1;
            if (sts.op == bsm_pkg::OP_SHOW_TOP) begin
               cmd.rsp_set = 1'b1;
               cmd.kind    = bsm_pkg::SHOW_HEX;
               cmd.ip_next = 1'b1;
               state_in    = S_RESP;
            end else begin
               cmd.rd_second = 1'b1;
               state_in      = S_READ_B;
            end
         end
         S_READ_B: begin
            cmd.load_b = 1'b1;
            if (sts.op == bsm_pkg::OP_CMP) begin
               cmd.cmp     = 1'b1;
               cmd.ip_next = 1'b1;
               cmd.rsp_set = 1'b1;
               state_in    = S_RESP;
            end else if (sts.op == bsm_pkg::OP_DIV) begin
               if (sts.b_zero) begin
                  cmd.halt    = 1'b1;
                  cmd.fault   = bsm_pkg::FAULT_DIV_ZERO;
                  cmd.rsp_set = 1'b1;
                  state_in    = S_RESP;
               end else begin
                  cmd.div_start = 1'b1;
                  state_in      = S_DIV;
               end
            end else begin
               state_in = S_STORE;
            end
         end
         S_DIV: begin
            if (sts.div_done) begin
               state_in = S_STORE;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         S_STORE: begin
            cmd.store   = 1'b1;
            cmd.ip_next = 1'b1;
            cmd.rsp_set = 1'b1;
            state_in    = S_RESP;
         end
         S_RESP: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `BSM_ASSERT_NOW(a_fetch_running, state_ff == S_FETCH, sts.running)
   `BSM_ASSERT_NEXT(a_rsp_hold, state_ff == S_RESP && !rsp_ready, state_ff == S_RESP)
   `BSM_ASSERT_NOW(a_div_nonzero, cmd.div_start, !sts.b_zero)

endmodule

@@ dv/byte_stack_machine_core_test.sv @@
`timescale 1ns / 100ps
// Self-checking bench for byte_stack_machine_core: random valid/ready traffic of program writes,
// starts and steps, checked against an in-bench machine shadow.
// Depends on bsm_pkg and the channel interfaces in bsm_ifs.sv.
module byte_stack_machine_core_test;

   localparam logic [1:0] REQ_UNUSED = 2'd3;
   localparam int IDLE_LIMIT = 2000;
   localparam int ITEM_TARGET = 600;

   typedef struct packed {
      logic [1:0] show_kind;
      logic [7:0] show_value;
      logic       is_running;
      logic [2:0] fault_code;
      logic [6:0] pointer_now;
   } machine_view_type;

   class machine_shadow;
      bit [11:0] words [bsm_pkg::PROG_WORDS];
      bit [7:0]  cells [bsm_pkg::STACK_WORDS];
      bit [6:0]  ip;
      bit [7:0]  depth;
      bit        eq_f, lt_f, run_f;
      machine_view_type pending_views [$];
      int failures;

      function new();
         foreach (words[i]) words[i] = '0;
         foreach (cells[i]) cells[i] = '0;
         ip = '0;
         depth = '0;
         eq_f = 1'b0;
         lt_f = 1'b0;
         run_f = 1'b0;
         failures = 0;
      endfunction

      function int pending();
         return pending_views.size();
      endfunction

      function void record_request(logic [1:0] opcode, logic [6:0] addr,
                                   logic [3:0] wop, logic [7:0] warg);
         machine_view_type v;
         bit [11:0] w;
         bit [3:0]  op;
         bit [7:0]  arg, a, b, r;
         bit [2:0]  flt;
         bit        hop;
         v = '0;
         v.show_kind = bsm_pkg::SHOW_NONE;
         flt = bsm_pkg::FAULT_NONE;
         a = '0;
         b = '0;
         r = '0;
         case (opcode)
            bsm_pkg::REQ_WRITE: begin
               words[addr] = {wop, warg};
            end
            bsm_pkg::REQ_START: begin
               ip = '0;
               depth = '0;
               eq_f = 1'b0;
               lt_f = 1'b0;
               run_f = 1'b1;
            end
            bsm_pkg::REQ_STEP: begin
               if (run_f) begin
                  w = words[ip];
                  op = w[11:8];
                  arg = w[7:0];
                  hop = 1'b0;
                  if (op >= bsm_pkg::OP_ADD && op <= bsm_pkg::OP_CMP) begin
                     if (depth < 2) flt = bsm_pkg::FAULT_UNDERFLOW;
                     else begin
                        a = cells[depth - 1];
                        b = cells[depth - 2];
                     end
                  end
                  if (flt == bsm_pkg::FAULT_NONE) begin
                     case (op) inside
                        bsm_pkg::OP_PUSH: begin
                           if (depth >= bsm_pkg::STACK_WORDS) flt = bsm_pkg::FAULT_OVERFLOW;
                           else begin
                              cells[depth] = arg;
                              depth++;
                           end
                        end
                        bsm_pkg::OP_POP: begin
                           if (depth == 0) flt = bsm_pkg::FAULT_UNDERFLOW;
                           else depth--;
                        end
                        bsm_pkg::OP_SHOW_TOP: begin
                           if (depth == 0) flt = bsm_pkg::FAULT_UNDERFLOW;
                           else begin
                              v.show_kind = bsm_pkg::SHOW_HEX;
                              v.show_value = cells[depth - 1];
                           end
                        end
                        bsm_pkg::OP_ADD, bsm_pkg::OP_SUB, bsm_pkg::OP_MUL,
                        bsm_pkg::OP_DIV: begin
                           case (op)
                              bsm_pkg::OP_ADD: r = a + b;
                              bsm_pkg::OP_SUB: r = a - b;
                              bsm_pkg::OP_MUL: r = a * b;
                              default: begin
                                 if (b == 0) flt = bsm_pkg::FAULT_DIV_ZERO;
                                 else r = a / b;
                              end
                           endcase
                           if (flt == bsm_pkg::FAULT_NONE) begin
                              depth--;
                              cells[depth - 1] = r;
                           end
                        end
                        bsm_pkg::OP_CMP: begin
                           eq_f = (a == b);
                           lt_f = (a < b);
                        end
                        bsm_pkg::OP_SHOW_CHAR: begin
                           v.show_kind = bsm_pkg::SHOW_CHAR;
                           v.show_value = arg;
                        end
                        bsm_pkg::OP_JMP: begin
                           ip = 7'(arg % bsm_pkg::PROG_WORDS);
                           hop = 1'b1;
                        end
                        bsm_pkg::OP_JEQ: begin
                           if (eq_f) begin
                              ip = 7'(arg % bsm_pkg::PROG_WORDS);
                              hop = 1'b1;
                           end
                        end
                        bsm_pkg::OP_JLT: begin
                           if (lt_f) begin
                              ip = 7'(arg % bsm_pkg::PROG_WORDS);
                              hop = 1'b1;
                           end
                        end
                        bsm_pkg::OP_JGT, bsm_pkg::OP_HALT: flt = bsm_pkg::FAULT_HALT;
                        default: ;
                     endcase
                  end
                  if (flt != bsm_pkg::FAULT_NONE) run_f = 1'b0;
                  else if (!hop) ip++;
               end
            end
            default: ;
         endcase
         v.fault_code = flt;
         v.is_running = run_f;
         v.pointer_now = ip;
         pending_views.push_back(v);
      endfunction

      function void compare_field(string name, logic [7:0] want, logic [7:0] got);
         if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            failures++;
         end
      endfunction

      function void check_response(machine_view_type seen);
         machine_view_type want;
         if (pending_views.size() == 0) begin
            $error("response transaction with no request outstanding");
            failures++;
         end else begin
            want = pending_views.pop_front();
            compare_field("show_kind", 8'(want.show_kind), 8'(seen.show_kind));
            compare_field("show_value", want.show_value, seen.show_value);
            compare_field("is_running", 8'(want.is_running), 8'(seen.is_running));
            compare_field("fault_code", 8'(want.fault_code), 8'(seen.fault_code));
            compare_field("pointer_now", 8'(want.pointer_now), 8'(seen.pointer_now));
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   bsm_req_if req_bus();
   bsm_rsp_if rsp_bus();

   byte_stack_machine_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus)
   );

   machine_shadow shadow;
   int  item_count;
   int  burst_left;
   bit  quiet_mode;
   int  idle_cycles;
   bit [7:0] stall_count;
   bit [1:0] stall_mode;

   always #1 clock = ~clock;

   always @(posedge clock) begin
      stall_count <= stall_count + 8'd1;
      if (stall_count[5:0] == 0) stall_mode <= 2'($urandom_range(0, 3));
      case (stall_mode)
         2'd0: rsp_bus.ready <= 1'b1;
         2'd1: rsp_bus.ready <= 1'($urandom_range(0, 1));
         2'd2: rsp_bus.ready <= (stall_count[1:0] == 2'd0);
         default: rsp_bus.ready <= stall_count[3];
      endcase
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            idle_cycles = 0;
         else
            idle_cycles = idle_cycles + 1;
         if (rsp_bus.valid && rsp_bus.ready)
            shadow.check_response({rsp_bus.show_kind, rsp_bus.show_value, rsp_bus.is_running,
                                   rsp_bus.fault_code, rsp_bus.pointer_now});
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("byte_stack_machine_core_test: FAIL");
            $finish;
         end
      end
   end

   task automatic send_request(input logic [1:0] opcode, input logic [6:0] addr,
                               input logic [3:0] wop, input logic [7:0] warg);
      int gap;
      if (burst_left == 0) begin
         gap = quiet_mode ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 8);
      end
      req_bus.valid        <= 1'b1;
      req_bus.opcode       <= opcode;
      req_bus.word_address <= addr;
      req_bus.word_op      <= wop;
      req_bus.word_arg     <= warg;
      do @(posedge clock); while (!req_bus.ready);
      shadow.record_request(opcode, addr, wop, warg);
      burst_left--;
      item_count++;
   endtask

   task automatic write_word(input logic [6:0] addr, input logic [3:0] wop,
                             input logic [7:0] warg);
      send_request(bsm_pkg::REQ_WRITE, addr, wop, warg);
   endtask

   task automatic start_machine();
      send_request(bsm_pkg::REQ_START, 7'($urandom_range(0, 127)),
                   4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
   endtask

   task automatic step_machine();
      send_request(bsm_pkg::REQ_STEP, 7'($urandom_range(0, 127)),
                   4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
   endtask

   task automatic send_noise();
      send_request(2'($urandom_range(0, 3)), 7'($urandom_range(0, 127)),
                   4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
   endtask

   // push loop until the stack is full, then one more push
   task automatic fill_stack();
      write_word(7'd0, bsm_pkg::OP_PUSH, 8'($urandom_range(0, 255)));
      write_word(7'd1, bsm_pkg::OP_JMP, {1'($urandom_range(0, 1)), 7'd0});
      start_machine();
      repeat (2 * bsm_pkg::STACK_WORDS + 2) step_machine();
   endtask

   task automatic run_program();
      int len, steps, pick;
      logic [3:0] op;
      logic [7:0] arg;
      len = $urandom_range(2, 20);
      for (int i = 0; i < len; i++) begin
         pick = $urandom_range(0, 99);
         arg = 8'($urandom_range(0, 255));
         if (pick < 35) begin
            op = bsm_pkg::OP_PUSH;
            case ($urandom_range(0, 7))
               0: arg = 8'd0;
               1: arg = 8'd1;
               2: arg = 8'hFF;
               default: ;
            endcase
         end else if (pick < 40) op = bsm_pkg::OP_POP;
         else if (pick < 62) op = 4'(bsm_pkg::OP_ADD + $urandom_range(0, 4));
         else if (pick < 68) op = bsm_pkg::OP_SHOW_TOP;
         else if (pick < 73) op = bsm_pkg::OP_SHOW_CHAR;
         else if (pick < 80) begin
            case ($urandom_range(0, 2))
               0: op = bsm_pkg::OP_JMP;
               1: op = bsm_pkg::OP_JEQ;
               default: op = bsm_pkg::OP_JLT;
            endcase
            if ($urandom_range(0, 3) != 0)
               arg = {1'($urandom_range(0, 1)), 7'($urandom_range(0, len - 1))};
         end else if (pick < 84)
            op = ($urandom_range(0, 1) != 0) ? bsm_pkg::OP_NOP : bsm_pkg::OP_INPUT;
         else if (pick < 87) op = bsm_pkg::OP_JGT;
         else if (pick < 90) op = bsm_pkg::OP_HALT;
         else op = 4'($urandom_range(0, 15));
         write_word(7'(i), op, arg);
      end
      start_machine();
      steps = $urandom_range(len, 3 * len + 10);
      for (int s = 0; s < steps; s++) begin
         if ($urandom_range(0, 24) == 0) send_noise();
         step_machine();
      end
   endtask

   initial begin
      req_bus.valid        = 1'b0;
      req_bus.opcode       = bsm_pkg::REQ_WRITE;
      req_bus.word_address = '0;
      req_bus.word_op      = bsm_pkg::OP_NOP;
      req_bus.word_arg     = '0;
      rsp_bus.ready        = 1'b0;
      shadow = new();
      item_count = 0;
      burst_left = 0;
      quiet_mode = 1'b0;
      idle_cycles = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: step before start, a short program with a taken jump, divide and underflow halt, step while halted
      step_machine();
      write_word(7'd0, bsm_pkg::OP_PUSH, 8'hFF);
      write_word(7'd1, bsm_pkg::OP_PUSH, 8'h00);
      write_word(7'd2, bsm_pkg::OP_CMP, 8'h00);
      write_word(7'd3, bsm_pkg::OP_JLT, 8'h86);
      write_word(7'd4, bsm_pkg::OP_HALT, 8'h00);
      write_word(7'd6, bsm_pkg::OP_SHOW_CHAR, 8'h41);
      write_word(7'd7, bsm_pkg::OP_DIV, 8'h00);
      write_word(7'd8, bsm_pkg::OP_SHOW_TOP, 8'h00);
      write_word(7'd9, bsm_pkg::OP_POP, 8'h00);
      write_word(7'd10, bsm_pkg::OP_POP, 8'h00);
      write_word(7'd127, bsm_pkg::OP_HALT, 8'hFF);
      start_machine();
      repeat (9) step_machine();
      step_machine();
      send_request(REQ_UNUSED, 7'h7F, 4'hF, 8'hFF);

      fill_stack();
      while (item_count < ITEM_TARGET) begin
         quiet_mode = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 9) == 0) repeat ($urandom_range(3, 10)) send_noise();
         else run_program();
      end
      req_bus.valid <= 1'b0;

      while (shadow.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (shadow.failures == 0)
         $display("byte_stack_machine_core_test: PASS");
      else
         $display("byte_stack_machine_core_test: FAIL");
      $finish;
   end
endmodule
